// ===== design/mgcn_pkg.sv =====
`default_nettype none
package mgcn_pkg;
  localparam int SampleWidth = 16;
  localparam int FracBits = SampleWidth - 1;
  localparam int MaxRows = 65536;
  localparam int CountWidth = 17;
  localparam int ProdWidth = 2 * SampleWidth;
  localparam int AccWidth = 48;
  localparam int SqWidth = 48;
  localparam int DivWidth = CountWidth + FracBits;
  localparam int OutWidth = 24;
  localparam int RootWidth = SqWidth / 2;
  localparam int QueueDepth = 4;
  localparam int QueuePtrWidth = 2;

  typedef struct packed {
    logic signed [ProdWidth-1:0] prod;
    logic col_end;
    logic grp_end;
    logic run_end;
  } mgcn_entry_t;
endpackage
`default_nettype wire

// ===== design/mgcn_front.sv =====
`default_nettype none
module mgcn_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [mgcn_pkg::CountWidth-1:0] eff_rows,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [mgcn_pkg::SampleWidth-1:0] in_x_value,
  input  wire logic signed [mgcn_pkg::SampleWidth-1:0] in_y_value,
  input  wire logic in_last_in_group,
  input  wire logic in_last_item,
  output logic q_valid,
  input  wire logic q_ready,
  output mgcn_pkg::mgcn_entry_t q_data
);
  import mgcn_pkg::*;

  mgcn_entry_t mem_r [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_r, rd_r;
  logic [QueuePtrWidth:0] cnt_r;
  logic [CountWidth-1:0] row_r, row_nxt;
  mgcn_entry_t ent;
  logic push, pop;

  assign in_ready = (cnt_r != QueueDepth[QueuePtrWidth:0]);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != '0);
  assign pop = q_valid && q_ready;
  assign q_data = mem_r[rd_r];
  assign row_nxt = row_r + 1'b1;

  always_comb begin
    ent.prod = in_x_value * in_y_value;
    ent.run_end = in_last_item;
    ent.col_end = (row_nxt >= eff_rows) || in_last_item;
    ent.grp_end = ent.col_end && (in_last_in_group || in_last_item);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= ent;
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
      row_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
        row_r <= ent.col_end ? '0 : row_nxt;
      end
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + {{QueuePtrWidth{1'b0}}, push} - {{QueuePtrWidth{1'b0}}, pop};
    end
  end
endmodule
`default_nettype wire

// ===== design/mgcn_back.sv =====
`default_nettype none
module mgcn_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [mgcn_pkg::CountWidth-1:0] eff_rows,
  input  wire logic q_valid,
  output logic q_ready,
  input  wire mgcn_pkg::mgcn_entry_t q_data,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [mgcn_pkg::OutWidth-1:0] out_max_norm
);
  import mgcn_pkg::*;

  localparam logic [2:0] StAcc = 3'd0;
  localparam logic [2:0] StDiv = 3'd1;
  localparam logic [2:0] StSq = 3'd2;
  localparam logic [2:0] StSum = 3'd3;
  localparam logic [2:0] StRoot = 3'd4;
  localparam logic [2:0] StOut = 3'd5;
  localparam int QuoWidth = AccWidth;
  localparam int DivCntWidth = $clog2(AccWidth + 1);
  localparam int RootCntWidth = $clog2(RootWidth + 1);

  logic [2:0] st_r;
  logic signed [AccWidth-1:0] acc_r;
  logic [SqWidth-1:0] grp_r, best_r;
  logic grp_end_r, run_end_r, neg_r;
  logic [AccWidth-1:0] rem_r, quo_r;
  logic [DivCntWidth-1:0] dcnt_r;
  logic [2*FracBits:0] sq_r;
  logic [SqWidth-1:0] rv_r;
  logic [RootWidth-1:0] root_r;
  logic [SqWidth+1:0] rrem_r;
  logic [RootCntWidth-1:0] rcnt_r;
  logic [OutWidth-1:0] out_r;

  logic signed [AccWidth:0] sum_w;
  logic signed [AccWidth-1:0] sat_w;
  logic [AccWidth-1:0] div_w;
  logic [AccWidth:0] trial;
  logic [SqWidth:0] gsum;
  logic [SqWidth-1:0] gsat;
  logic [SqWidth+1:0] rshift, rtrial;
  logic [FracBits:0] mean_mag;

  assign q_ready = (st_r == StAcc);
  assign out_valid = (st_r == StOut);
  assign out_max_norm = out_r;
  assign div_w = {{(AccWidth-DivWidth){1'b0}}, eff_rows, {FracBits{1'b0}}};

  always_comb begin
    sum_w = {acc_r[AccWidth-1], acc_r} +
            {{(AccWidth+1-ProdWidth){q_data.prod[ProdWidth-1]}}, q_data.prod};
    if (sum_w[AccWidth] != sum_w[AccWidth-1])
      sat_w = sum_w[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
    else
      sat_w = sum_w[AccWidth-1:0];
    trial = {1'b0, rem_r[AccWidth-2:0], quo_r[AccWidth-1]} - {1'b0, div_w};
    mean_mag = (quo_r > {{(AccWidth-FracBits){1'b0}}, {FracBits{1'b1}}}) ?
               (neg_r ? {1'b1, {FracBits{1'b0}}} : {1'b0, {FracBits{1'b1}}}) :
               quo_r[FracBits:0];
    gsum = {1'b0, grp_r} + {{(SqWidth-2*FracBits){1'b0}}, sq_r};
    gsat = gsum[SqWidth] ? '1 : gsum[SqWidth-1:0];
    rshift = {rrem_r[SqWidth-1:0], rv_r[SqWidth-1:SqWidth-2]};
    rtrial = rshift - {{(SqWidth+2-RootWidth-2){1'b0}}, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StAcc;
      acc_r <= '0;
      grp_r <= '0;
      best_r <= '0;
    end else begin
      case (st_r)
        StAcc: if (q_valid) begin
          grp_end_r <= q_data.grp_end;
          run_end_r <= q_data.run_end;
          if (q_data.col_end) begin
            neg_r <= sat_w[AccWidth-1];
            quo_r <= sat_w[AccWidth-1] ? 48'(-sat_w) : sat_w;
            rem_r <= '0;
            dcnt_r <= '0;
            acc_r <= '0;
            st_r <= StDiv;
          end else begin
            acc_r <= sat_w;
          end
        end
        StDiv: begin
          if (!trial[AccWidth]) begin
            rem_r <= trial[AccWidth-1:0];
            quo_r <= {quo_r[AccWidth-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[AccWidth-2:0], quo_r[AccWidth-1]};
            quo_r <= {quo_r[AccWidth-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DivCntWidth'(QuoWidth - 1)) st_r <= StSq;
        end
        StSq: begin
          sq_r <= (2*FracBits+1)'(mean_mag * mean_mag);
          st_r <= StSum;
        end
        StSum: begin
          if (grp_end_r) begin
            grp_r <= '0;
            if (run_end_r) begin
              rv_r <= (gsat > best_r) ? gsat : best_r;
              root_r <= '0;
              rrem_r <= '0;
              rcnt_r <= '0;
              best_r <= '0;
              st_r <= StRoot;
            end else begin
              if (gsat > best_r) best_r <= gsat;
              st_r <= StAcc;
            end
          end else begin
            grp_r <= gsat;
            st_r <= StAcc;
          end
        end
        StRoot: begin
          rv_r <= {rv_r[SqWidth-3:0], 2'b00};
          if (!rtrial[SqWidth+1]) begin
            rrem_r <= rtrial;
            root_r <= {root_r[RootWidth-2:0], 1'b1};
          end else begin
            rrem_r <= rshift;
            root_r <= {root_r[RootWidth-2:0], 1'b0};
          end
          rcnt_r <= rcnt_r + 1'b1;
          if (rcnt_r == RootCntWidth'(RootWidth - 1)) st_r <= StOut;
        end
        StOut: if (out_ready) st_r <= StAcc;
        default: st_r <= StAcc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == StRoot && rcnt_r == RootCntWidth'(RootWidth - 1))
      out_r <= OutWidth'({root_r[RootWidth-2:0], !rtrial[SqWidth+1]});
  end
endmodule
`default_nettype wire

// ===== design/max_group_correlation_norm_unit.sv =====
`default_nettype none
// Streams column-major matrix elements with their response elements and returns, on the
// request flagged last_item, the largest group L2 norm of column means in unsigned Q9.15.
// The front multiplies each request and queues it; the back accumulates one request per
// cycle inside a column. A column close runs a 48-step divider, square and group update;
// a run end adds square-root iteration before the result. cfg_ sets the row count (0 acts
// as 1, above 65536 clamps); the user writes it only while idle, the block does not check.
module max_group_correlation_norm_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [mgcn_pkg::CountWidth-1:0] cfg_sample_count,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [mgcn_pkg::SampleWidth-1:0] in_x_value,
  input  wire logic signed [mgcn_pkg::SampleWidth-1:0] in_y_value,
  input  wire logic in_last_in_group,
  input  wire logic in_last_item,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [mgcn_pkg::OutWidth-1:0] out_max_norm
);
  import mgcn_pkg::*;

  logic [CountWidth-1:0] cnt_r, eff_rows;
  logic q_valid, q_ready;
  mgcn_entry_t q_data;

  assign cfg_ready = 1'b1;
  assign eff_rows = (cnt_r == '0) ? CountWidth'(1) :
                    (cnt_r > CountWidth'(MaxRows)) ? CountWidth'(MaxRows) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= CountWidth'(1);
    else if (cfg_valid) cnt_r <= cfg_sample_count;
  end

  mgcn_front u_front (
    .clk, .rst_n, .eff_rows, .in_valid, .in_ready, .in_x_value, .in_y_value,
    .in_last_in_group, .in_last_item, .q_valid, .q_ready, .q_data
  );

  mgcn_back u_back (
    .clk, .rst_n, .eff_rows, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_max_norm
  );
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mgcn_pkg::*;

  localparam longint unsigned SqMax = 48'hFFFF_FFFF_FFFF;
  localparam longint AccMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AccMin = -AccMax - 1;
  localparam int CycleLimit = 2000000;
  localparam int DrainCycles = 120;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CountWidth-1:0] cfg_sample_count;
  logic in_valid;
  logic in_ready;
  logic signed [SampleWidth-1:0] in_x_value;
  logic signed [SampleWidth-1:0] in_y_value;
  logic in_last_in_group;
  logic in_last_item;
  logic out_valid;
  logic out_ready;
  logic [OutWidth-1:0] out_max_norm;

  max_group_correlation_norm_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_sample_count(cfg_sample_count),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_x_value(in_x_value),
    .in_y_value(in_y_value),
    .in_last_in_group(in_last_in_group),
    .in_last_item(in_last_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_max_norm(out_max_norm)
  );

  // predictor state
  logic [CountWidth-1:0] rows_cfg;
  longint dot_sum;
  int unsigned rows_seen;
  longint unsigned grp_sq_sum;
  longint unsigned best_sq_sum;
  logic [OutWidth-1:0] expected_norms[$];

  int errors;
  int cycles;
  bit no_idle;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void norm_predict(logic signed [SampleWidth-1:0] x,
                                       logic signed [SampleWidth-1:0] y,
                                       logic grp, logic run);
    longint eff;
    longint s;
    longint m;
    longint unsigned mag;
    longint unsigned r;
    eff = (rows_cfg == 0) ? 1 : ((rows_cfg > MaxRows) ? MaxRows : rows_cfg);
    s = dot_sum + longint'(x) * longint'(y);
    if (s > AccMax) s = AccMax;
    if (s < AccMin) s = AccMin;
    dot_sum = s;
    rows_seen = (rows_seen + 1) & 32'h1FFFF;
    if (rows_seen >= eff || run) begin
      m = dot_sum / (eff << FracBits);
      if (m > 32767) m = 32767;
      if (m < -32768) m = -32768;
      mag = (m < 0) ? longint'(-m) : longint'(m);
      grp_sq_sum = grp_sq_sum + mag * mag;
      if (grp_sq_sum > SqMax) grp_sq_sum = SqMax;
      dot_sum = 0;
      rows_seen = 0;
      if (grp || run) begin
        if (grp_sq_sum > best_sq_sum) best_sq_sum = grp_sq_sum;
        grp_sq_sum = 0;
      end
    end
    if (run) begin
      r = root_floor(best_sq_sum);
      if (r > 64'hFF_FFFF) r = 64'hFF_FFFF;
      expected_norms.push_back(r[OutWidth-1:0]);
      dot_sum = 0;
      rows_seen = 0;
      grp_sq_sum = 0;
      best_sq_sum = 0;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_norms.size() == 0) begin
        report_mismatch($sformatf("unexpected max_norm %0d", out_max_norm));
      end else begin
        if (out_max_norm !== expected_norms[0])
          report_mismatch($sformatf("max_norm got %0d want %0d",
                                    out_max_norm, expected_norms[0]));
        void'(expected_norms.pop_front());
      end
    end
  end

  // result receiver
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(logic signed [SampleWidth-1:0] x,
                           logic signed [SampleWidth-1:0] y,
                           logic grp, logic run);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_x_value <= x;
    in_y_value <= y;
    in_last_in_group <= grp;
    in_last_item <= run;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    norm_predict(x, y, grp, run);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_norms.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_rows(logic [CountWidth-1:0] n);
    cfg_sample_count <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    rows_cfg = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SampleWidth-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // one run: ncols columns, random group ends, optional early end
  task automatic send_run(int ncols, int n_eff, bit early);
    int stop_col;
    int stop_row;
    logic grp;
    stop_col = early ? $urandom_range(0, ncols - 1) : ncols - 1;
    stop_row = early ? $urandom_range(0, n_eff - 1) : n_eff - 1;
    for (int c = 0; c <= stop_col; c++) begin
      grp = $urandom_range(0, 2) == 0;
      for (int r = 0; r < n_eff; r++) begin
        if (c == stop_col && r == stop_row) begin
          send_item(pick_sample(), pick_sample(), logic'($urandom_range(0, 1)), 1'b1);
          return;
        end
        send_item(pick_sample(), pick_sample(),
                  (r == n_eff - 1) ? grp : logic'($urandom_range(0, 1)), 1'b0);
      end
    end
  endtask

  task automatic test_extremes();
    send_item(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
    send_item(16'sh8000, 16'sh8000, 1'b1, 1'b0);
    send_item(16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
    send_item(16'sh0000, 16'sh0000, 1'b0, 1'b1);
    send_item(16'sh0001, 16'shFFFF, 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_group_flags();
    write_rows(17'd3);
    send_item(16'sh4000, 16'sh4000, 1'b1, 1'b0);
    send_item(16'sh4000, 16'sh4000, 1'b1, 1'b0);
    send_item(16'sh4000, 16'sh4000, 1'b0, 1'b0);
    send_item(16'sh2000, 16'sh7FFF, 1'b0, 1'b0);
    send_item(16'sh2000, 16'sh7FFF, 1'b0, 1'b0);
    send_item(16'sh2000, 16'sh7FFF, 1'b1, 1'b0);
    send_item(16'sh1000, 16'sh8000, 1'b0, 1'b0);
    send_item(16'sh1000, 16'sh8000, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_zero_rows();
    write_rows(17'd0);
    send_item(16'sh8000, 16'sh8000, 1'b0, 1'b0);
    send_item(16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
    send_item(16'sh1234, 16'sh5678, 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_clamped_rows();
    write_rows(17'h1FFFF);
    send_item(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
    send_item(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1);
    wait_idle();
  endtask

  // a full column of extreme samples, means saturate
  task automatic test_full_column();
    write_rows(17'd256);
    no_idle = 1'b1;
    for (int r = 0; r < 256; r++)
      send_item(16'sh8000, 16'sh8000, 1'b1, r == 255);
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_rows(17'd2);
    hold_cycles = 400;
    no_idle = 1'b1;
    for (int k = 0; k < 6; k++) send_run(3, 2, 1'b0);
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_random();
    int n;
    int n_eff;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: n = 1;
        1: n = 0;
        default: n = $urandom_range(1, 6);
      endcase
      write_rows(n[CountWidth-1:0]);
      n_eff = (n == 0) ? 1 : n;
      no_idle = (ph == 3);
      for (int k = 0; k < 12; k++) begin
        send_run($urandom_range(1, 5), n_eff, $urandom_range(0, 4) == 0);
        if (k == 10) begin
          // sender pauses until all results are back
          in_valid <= 1'b0;
          while (expected_norms.size() != 0) @(negedge clk);
        end
      end
      no_idle = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    no_idle = 1'b0;
    hold_cycles = 0;
    rows_cfg = 1;
    dot_sum = 0;
    rows_seen = 0;
    grp_sq_sum = 0;
    best_sq_sum = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_sample_count = '0;
    in_valid = 1'b0;
    in_x_value = '0;
    in_y_value = '0;
    in_last_in_group = 1'b0;
    in_last_item = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_group_flags();
    test_zero_rows();
    test_clamped_rows();
    test_full_column();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
